[rtl/ttpr_pkg.sv]
package ttpr_pkg;

    localparam int unsigned DUTY_W   = 7;
    localparam int unsigned SCALE_W  = 8;
    localparam int unsigned UPD_W    = 8;
    localparam int unsigned BLINK_W  = 10;
    localparam int unsigned CMP_W    = 8;
    localparam int unsigned PROD_W   = DUTY_W + SCALE_W;
    localparam int unsigned CFG_DW   = 10;
    localparam int unsigned CFG_AW   = 3;

    // Division by 100 as a multiply by 5243 and a shift by 19, exact below 43699.
    localparam int unsigned RECIP_W     = 13;
    localparam int unsigned RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
    localparam int unsigned QUOT_W      = PROD_W + RECIP_W - RECIP_SHIFT;

    localparam logic [DUTY_W-1:0]  DUTY_MIN_RST      = 7'd0;
    localparam logic [DUTY_W-1:0]  DUTY_MAX_RST      = 7'd100;
    localparam logic [SCALE_W-1:0] SCALE_FACTOR_RST  = 8'd250;
    localparam logic [UPD_W-1:0]   UPDATE_PERIOD_RST = 8'd10;
    localparam logic [BLINK_W-1:0] BLINK_PERIOD_RST  = 10'd1000;
    localparam logic [DUTY_W-1:0]  DUTY_TOP          = 7'd127;
    localparam logic [CMP_W-1:0]   CMP_FULL          = 8'hFF;

    typedef enum logic [CFG_AW-1:0] {
        CFG_DUTY_MIN      = 3'd0,
        CFG_DUTY_MAX      = 3'd1,
        CFG_SCALE_FACTOR  = 3'd2,
        CFG_UPDATE_PERIOD = 3'd3,
        CFG_BLINK_PERIOD  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [DUTY_W-1:0]  duty_min;
        logic [DUTY_W-1:0]  duty_max;
        logic [SCALE_W-1:0] scale_factor;
        logic [UPD_W-1:0]   update_period;
        logic [BLINK_W-1:0] blink_period;
    } ttpr_cfg_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              running;
        logic              led;
    } ttpr_status_t;

endpackage

[rtl/ttpr_tick.sv]
module ttpr_tick
    import ttpr_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         tick_accept,
    input  logic         switch_level,
    input  ttpr_cfg_t    cfg,
    output ttpr_status_t status
);

    logic [BLINK_W-1:0] blink_count_reg, blink_count_next;
    logic               led_reg, led_next;
    logic [UPD_W-1:0]   update_count_reg, update_count_next;
    logic               prev_level_reg, prev_level_next;
    logic               running_reg, running_next;
    logic [DUTY_W-1:0]  duty_reg, duty_next;
    logic               going_up_reg, going_up_next;

    logic [BLINK_W:0]   blink_inc;
    logic [UPD_W:0]     update_inc;
    logic               update_hit;
    logic               run_a;
    logic               up_a;
    logic [DUTY_W-1:0]  duty_a;
    logic [DUTY_W-1:0]  duty_b;
    logic               turn;

    always_comb begin
        blink_inc  = {1'b0, blink_count_reg} + {{BLINK_W{1'b0}}, 1'b1};
        update_inc = {1'b0, update_count_reg} + {{UPD_W{1'b0}}, 1'b1};
        update_hit = update_inc >= {1'b0, cfg.update_period};

        blink_count_next = blink_inc[BLINK_W-1:0];
        led_next         = led_reg;
        if (blink_inc >= {1'b0, cfg.blink_period}) begin
            blink_count_next = '0;
            led_next         = ~led_reg;
        end

        update_count_next = update_hit ? '0 : update_inc[UPD_W-1:0];

        // A falling edge of the sampled switch restarts the ramp.
        if (prev_level_reg && !switch_level) begin
            run_a  = 1'b1;
            duty_a = cfg.duty_min;
            up_a   = 1'b1;
        end else begin
            run_a  = running_reg;
            duty_a = duty_reg;
            up_a   = going_up_reg;
        end

        duty_b = duty_a;
        if (run_a) begin
            if (up_a) begin
                if (duty_a < DUTY_TOP) begin
                    duty_b = duty_a + 7'd1;
                end
            end else if (duty_a != '0) begin
                duty_b = duty_a - 7'd1;
            end
        end else begin
            duty_b = cfg.duty_min;
            up_a   = 1'b1;
        end

        turn = (cfg.duty_max == '0) || (duty_b >= cfg.duty_max - 7'd1);

        prev_level_next = prev_level_reg;
        running_next    = running_reg;
        duty_next       = duty_reg;
        going_up_next   = going_up_reg;
        if (update_hit) begin
            prev_level_next = switch_level;
            duty_next       = duty_b;
            going_up_next   = turn ? 1'b0 : up_a;
            running_next    = (duty_b <= cfg.duty_min) ? 1'b0 : run_a;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blink_count_reg  <= '0;
            led_reg          <= 1'b0;
            update_count_reg <= '0;
            prev_level_reg   <= 1'b0;
            running_reg      <= 1'b0;
            duty_reg         <= DUTY_MIN_RST;
            going_up_reg     <= 1'b1;
        end else if (tick_accept) begin
            blink_count_reg  <= blink_count_next;
            led_reg          <= led_next;
            update_count_reg <= update_count_next;
            prev_level_reg   <= prev_level_next;
            running_reg      <= running_next;
            duty_reg         <= duty_next;
            going_up_reg     <= going_up_next;
        end
    end

    assign status.duty    = duty_reg;
    assign status.running = running_reg;
    assign status.led     = led_reg;

endmodule

[rtl/triggered_triangle_pwm_ramp.sv]
// Channel   | Handshake          | Payload
// ----------+--------------------+------------------------------------------------
// input     | s_valid / s_ready  | s_switch_level
// result    | m_valid / m_ready  | m_compare_value, m_duty_percent,
//           |                    | m_ramp_running, m_led_level
// config    | cfg_wr_en          | cfg_addr, cfg_wdata
//
// One tick transaction is accepted per clock unless a held result stalls the pipeline.
// The counters and ramp state update in the accept cycle, then the duty times scale
// product and the divide by 100 each take one registered stage.
// Reset is synchronous and active low; it restores the configuration, tick state and valid
// registers to their defaults. When the result is held by a low m_ready, the whole pipeline stalls together.
module triggered_triangle_pwm_ramp
    import ttpr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_switch_level,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CMP_W-1:0]    m_compare_value,
    output logic [DUTY_W-1:0]   m_duty_percent,
    output logic                m_ramp_running,
    output logic                m_led_level,
    input  logic                cfg_wr_en,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [CFG_DW-1:0]   cfg_wdata
);

    ttpr_cfg_t    cfg_reg;
    ttpr_status_t status;
    logic         advance;

    logic                      v1_reg;
    logic                      v2_reg;
    logic [PROD_W-1:0]         prod_reg;
    ttpr_status_t              st2_reg;
    logic                      m_valid_reg;
    logic [CMP_W-1:0]          cmp_reg;
    ttpr_status_t              st3_reg;

    logic [PROD_W+RECIP_W-1:0] recip_prod;
    logic [QUOT_W-1:0]         quot;
    logic [CMP_W-1:0]          scaled;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.duty_min      <= DUTY_MIN_RST;
            cfg_reg.duty_max      <= DUTY_MAX_RST;
            cfg_reg.scale_factor  <= SCALE_FACTOR_RST;
            cfg_reg.update_period <= UPDATE_PERIOD_RST;
            cfg_reg.blink_period  <= BLINK_PERIOD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_DUTY_MIN:      cfg_reg.duty_min      <= cfg_wdata[DUTY_W-1:0];
                CFG_DUTY_MAX:      cfg_reg.duty_max      <= cfg_wdata[DUTY_W-1:0];
                CFG_SCALE_FACTOR:  cfg_reg.scale_factor  <= cfg_wdata[SCALE_W-1:0];
                CFG_UPDATE_PERIOD: cfg_reg.update_period <= cfg_wdata[UPD_W-1:0];
                CFG_BLINK_PERIOD:  cfg_reg.blink_period  <= cfg_wdata[BLINK_W-1:0];
                default: ;
            endcase
        end
    end

    ttpr_tick u_tick (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tick_accept  (s_valid && advance),
        .switch_level (s_switch_level),
        .cfg          (cfg_reg),
        .status       (status)
    );

    always_comb begin
        recip_prod = {{RECIP_W{1'b0}}, prod_reg} * {{PROD_W{1'b0}}, RECIP_100};
        quot       = recip_prod[PROD_W+RECIP_W-1:RECIP_SHIFT];
        scaled     = (quot > {{(QUOT_W-CMP_W){1'b0}}, CMP_FULL}) ? CMP_FULL
                                                                 : quot[CMP_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            m_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            prod_reg <= PROD_W'({{SCALE_W{1'b0}}, status.duty}
                               * {{DUTY_W{1'b0}}, cfg_reg.scale_factor});
            st2_reg  <= status;
            cmp_reg  <= CMP_FULL - scaled;
            st3_reg  <= st2_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_compare_value = cmp_reg;
    assign m_duty_percent  = st3_reg.duty;
    assign m_ramp_running  = st3_reg.running;
    assign m_led_level     = st3_reg.led;

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v1_reg)
        else $error("Accepted tick did not enter the pipeline.");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(v2_reg))
        else $error("Result appeared without a tick in the product stage.");

    a_zero_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_duty_percent == '0 |-> m_compare_value == CMP_FULL)
        else $error("Zero duty must give a full compare value.");

endmodule
